// File: src/pawja_pkg.sv
package pawja_pkg;

  localparam int IDX_W       = 10;
  localparam int POS_W       = 24;
  localparam int RK_W        = 5;
  localparam int D2_W        = 50;  // sum of three squared 24-bit magnitudes
  localparam int ROOT_W      = 25;
  localparam int SQRT_STEPS  = 25;  // one result bit per step
  localparam int SQ_REM_W    = 27;

  localparam logic [RK_W-1:0]  RK_RESET = 5'd16;
  localparam logic [POS_W-1:0] JIT_MAX  = 24'hFF_FFFF;

  localparam logic [1:0] REG_RECORDS_KEPT = 2'd0;

endpackage

// File: src/per_atom_windowed_jitter_average.sv
// Per-atom windowed jitter average.
// Input channel: in_valid / in_stall carry one item (atom_index, atom_fixed,
// pos_x/y/z). Output channel: out_valid / out_stall carry one result item
// (atom_echo, average_jitter, average_valid) for each item no port write drops.
// An item is taken when valid is high and stall is low at a clock edge.
// Items are worked one at a time from the atom record memory:
//   moving atom, not first position: record read, 4 multiply steps,
//     25 square-root steps, record update, 28 divide steps, one per bit of
//     the running sum, then result load.
//   fixed atom with two or more positions: record read, divide, result load.
//   first position or fixed atom without a window: record read, result load.
//   index out of range: straight to result load.
// The next item is taken in the cycle after the result loads, so no item is
// taken while another is in work.
// The output register holds a finished result while the receiver stalls;
// the block then waits with in_stall high before taking its next item.
// Reset (rst, synchronous) sets records_kept to 16 and runs a clearing pass
// over every record in memory, in_stall high throughout.
// Any write sets records_kept and starts the clearing pass, restarting every
// window under the new size. Configuration goes through an APB-style port.
module per_atom_windowed_jitter_average import pawja_pkg::*; #(
  parameter int ATOM_COUNT = 1024,
  parameter int RING_SLOTS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [IDX_W-1:0]        atom_index,
  input  logic                    atom_fixed,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic signed [POS_W-1:0] pos_z,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [IDX_W-1:0]        atom_echo,
  output logic [POS_W-1:0]        average_jitter,
  output logic                    average_valid,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [1:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int AW     = (ATOM_COUNT > 1) ? $clog2(ATOM_COUNT) : 1;
  localparam int PW     = $clog2(RING_SLOTS);
  localparam int CW     = $clog2(RING_SLOTS + 1);
  localparam int SW     = POS_W + $clog2(RING_SLOTS);
  localparam int STEP_W = $clog2(((SW > SQRT_STEPS) ? SW : SQRT_STEPS) + 1);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_READ  = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_SQRT  = 4'd4;
  localparam logic [3:0] S_UPD   = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_DONE  = 4'd7;

  // Per-atom record: window control plus last position.
  typedef struct packed {
    logic [CW-1:0]           seen;
    logic [PW-1:0]           ptr;
    logic [SW-1:0]           sum;
    logic signed [POS_W-1:0] lx;
    logic signed [POS_W-1:0] ly;
    logic signed [POS_W-1:0] lz;
  } rec_t;

  rec_t              rec_mem [ATOM_COUNT];
  logic [POS_W-1:0]  ring_mem [2**(AW+PW)];

  logic [3:0]        state;
  logic [AW-1:0]     clr_cnt;
  logic [RK_W-1:0]   records_kept;

  rec_t              rec_rd;
  logic              rec_we;
  logic [AW-1:0]     rec_waddr;
  rec_t              rec_wdata;
  logic [AW+PW-1:0]  ring_raddr;
  logic [POS_W-1:0]  ring_rd;

  // item being worked
  logic [IDX_W-1:0]        item_idx;
  logic [AW-1:0]           item_addr;
  logic                    item_fixed;
  logic signed [POS_W-1:0] item_x, item_y, item_z;
  logic [CW-1:0]           seen_r;
  logic [SW-1:0]           sum_r;
  logic [PW-1:0]           cur_r, nxt_r;
  logic [POS_W-1:0]        ax, ay, az;

  logic [STEP_W-1:0]       step;
  logic [2*POS_W-1:0]      prod;
  logic [D2_W-1:0]         acc;
  logic [SQ_REM_W-1:0]     sq_rem;
  logic [ROOT_W-1:0]       sq_root;
  logic [SW-1:0]           div_num;
  logic [CW-1:0]           div_rem, div_den;
  logic [POS_W-1:0]        res_avg;
  logic                    res_ok;

  logic                    cfg_wr, in_accept, in_range, out_load;
  logic [CW-1:0]           win;
  logic [PW-1:0]           nxt;
  logic [POS_W-1:0]        mul_a;
  logic [SQ_REM_W+1:0]     sq_remx, sq_trial;
  logic                    sq_ge;
  logic [CW:0]             div_r2;
  logic                    div_ge;
  logic [POS_W-1:0]        jit;
  logic                    full;
  logic [SW-1:0]           sum_new;
  logic [CW-1:0]           seen_new;

  function automatic logic [POS_W-1:0] abs_diff(logic signed [POS_W-1:0] a,
                                                logic signed [POS_W-1:0] b);
    logic signed [POS_W:0] d;
    d = {a[POS_W-1], a} - {b[POS_W-1], b};
    return d[POS_W] ? POS_W'(-d) : d[POS_W-1:0];
  endfunction

  assign pready    = 1'b1;
  assign prdata    = (paddr == REG_RECORDS_KEPT) ? {{(32-RK_W){1'b0}}, records_kept} : '0;
  assign cfg_wr    = psel && penable && pwrite;
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign in_range  = 32'(atom_index) < ATOM_COUNT;
  // finished result moves into the output register
  assign out_load  = !cfg_wr && (state == S_DONE) && (!out_valid || !out_stall);

  // effective window: records_kept clamped to [2, RING_SLOTS]
  always_comb begin
    if (records_kept < RK_W'(2)) begin
      win = CW'(2);
    end else if (32'(records_kept) > RING_SLOTS) begin
      win = CW'(RING_SLOTS);
    end else begin
      win = CW'(records_kept);
    end
  end

  assign nxt = ((CW'(rec_rd.ptr) + CW'(1)) == win) ? '0 : PW'(rec_rd.ptr + PW'(1));

  always_comb begin
    case (step[1:0])
      2'd0:    mul_a = ax;
      2'd1:    mul_a = ay;
      default: mul_a = az;
    endcase
  end

  // one square-root digit per step
  assign sq_remx  = {sq_rem, acc[D2_W-1 -: 2]};
  assign sq_trial = (SQ_REM_W+2)'({sq_root, 2'b01});
  assign sq_ge    = sq_remx >= sq_trial;

  // one quotient bit per step
  assign div_r2 = {div_rem, div_num[SW-1]};
  assign div_ge = div_r2 >= {1'b0, div_den};

  assign jit      = sq_root[ROOT_W-1] ? JIT_MAX : sq_root[POS_W-1:0];
  assign full     = seen_r >= win;
  assign seen_new = full ? win : CW'(seen_r + CW'(1));
  always_comb begin
    sum_new = sum_r;
    if (full) begin
      sum_new = (sum_r >= SW'(ring_rd)) ? SW'(sum_r - SW'(ring_rd)) : '0;
    end
    sum_new = SW'(sum_new + SW'(jit));
  end

  // record write port: clearing pass, first position, window update
  always_comb begin
    rec_we        = 1'b0;
    rec_waddr     = item_addr;
    rec_wdata     = '0;
    rec_wdata.lx  = item_x;
    rec_wdata.ly  = item_y;
    rec_wdata.lz  = item_z;
    case (state)
      S_CLEAR: begin
        rec_we    = 1'b1;
        rec_waddr = clr_cnt;
        rec_wdata = '0;
      end
      S_READ: begin
        if (!item_fixed && rec_rd.seen == '0) begin
          rec_we         = 1'b1;
          rec_wdata.seen = CW'(1);
          rec_wdata.ptr  = rec_rd.ptr;
          rec_wdata.sum  = rec_rd.sum;
        end
      end
      S_UPD: begin
        rec_we         = 1'b1;
        rec_wdata.seen = seen_new;
        rec_wdata.ptr  = nxt_r;
        rec_wdata.sum  = sum_new;
      end
      default: rec_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    rec_rd <= rec_mem[AW'(atom_index)];
    if (rec_we) begin
      rec_mem[rec_waddr] <= rec_wdata;
    end
  end

  always_ff @(posedge clk) begin
    ring_rd <= ring_mem[ring_raddr];
    if (state == S_UPD) begin
      ring_mem[{item_addr, cur_r}] <= jit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_cnt      <= '0;
      records_kept <= RK_RESET;
      out_valid    <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_wr) begin
        records_kept <= pwdata[RK_W-1:0];
        state        <= S_CLEAR;
        clr_cnt      <= '0;
      end else begin
        case (state)
          S_CLEAR: begin
            clr_cnt <= AW'(clr_cnt + AW'(1));
            if (clr_cnt == AW'(ATOM_COUNT - 1)) begin
              state <= S_IDLE;
            end
          end
          S_IDLE: begin
            if (in_accept) begin
              item_idx   <= atom_index;
              item_addr  <= AW'(atom_index);
              item_fixed <= atom_fixed;
              item_x     <= pos_x;
              item_y     <= pos_y;
              item_z     <= pos_z;
              if (in_range) begin
                state <= S_READ;
              end else begin
                res_avg <= '0;
                res_ok  <= 1'b0;
                state   <= S_DONE;
              end
            end
          end
          S_READ: begin
            seen_r     <= rec_rd.seen;
            sum_r      <= rec_rd.sum;
            cur_r      <= rec_rd.ptr;
            nxt_r      <= nxt;
            ring_raddr <= {item_addr, nxt};
            ax         <= abs_diff(item_x, rec_rd.lx);
            ay         <= abs_diff(item_y, rec_rd.ly);
            az         <= abs_diff(item_z, rec_rd.lz);
            step       <= '0;
            res_avg    <= '0;
            res_ok     <= 1'b0;
            if (item_fixed) begin
              if (rec_rd.seen >= CW'(2)) begin
                div_num <= rec_rd.sum;
                div_den <= CW'(rec_rd.seen - CW'(1));
                div_rem <= '0;
                state   <= S_DIV;
              end else begin
                state <= S_DONE;
              end
            end else if (rec_rd.seen == '0) begin
              state <= S_DONE;
            end else begin
              state <= S_MUL;
            end
          end
          S_MUL: begin
            prod <= mul_a * mul_a;
            step <= (step == STEP_W'(3)) ? '0 : STEP_W'(step + STEP_W'(1));
            if (step == STEP_W'(1)) begin
              acc <= D2_W'(prod);
            end else if (step != '0) begin
              acc <= D2_W'(acc + D2_W'(prod));
            end
            if (step == STEP_W'(3)) begin
              sq_rem  <= '0;
              sq_root <= '0;
              state   <= S_SQRT;
            end
          end
          S_SQRT: begin
            acc     <= acc << 2;
            sq_rem  <= sq_ge ? SQ_REM_W'(sq_remx - sq_trial) : SQ_REM_W'(sq_remx);
            sq_root <= {sq_root[ROOT_W-2:0], sq_ge};
            step    <= STEP_W'(step + STEP_W'(1));
            if (step == STEP_W'(SQRT_STEPS - 1)) begin
              state <= S_UPD;
            end
          end
          S_UPD: begin
            div_num <= sum_new;
            div_den <= CW'(seen_new - CW'(1));
            div_rem <= '0;
            step    <= '0;
            state   <= S_DIV;
          end
          S_DIV: begin
            div_rem <= div_ge ? CW'(div_r2 - {1'b0, div_den}) : CW'(div_r2);
            div_num <= {div_num[SW-2:0], div_ge};
            step    <= STEP_W'(step + STEP_W'(1));
            if (step == STEP_W'(SW - 1)) begin
              // last bit: saturate the quotient to the result width
              res_avg <= (|div_num[SW-2:POS_W-1]) ? JIT_MAX
                                                   : {div_num[POS_W-2:0], div_ge};
              res_ok  <= 1'b1;
              state   <= S_DONE;
            end
          end
          S_DONE: begin
            if (out_load) begin
              atom_echo      <= item_idx;
              average_jitter <= res_avg;
              average_valid  <= res_ok;
              state          <= S_IDLE;
            end
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

endmodule

// File: src/pawja_check.sv
module pawja_check import pawja_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [POS_W-1:0] average_jitter,
  input logic             average_valid,
  input logic             psel,
  input logic             penable,
  input logic             pwrite
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(average_jitter)
                               && $stable(average_valid))
    else $error("stalled result changed");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("item taken while busy");

  // no window means a zero average
  a_zero_avg: assert property (@(posedge clk) disable iff (rst)
    out_valid && !average_valid |-> average_jitter == '0)
    else $error("nonzero average without window");

  // register write starts the clearing pass
  a_cfg_clear: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite |=> in_stall)
    else $error("no clearing pass after register write");

endmodule

bind per_atom_windowed_jitter_average pawja_check u_pawja_check (.*);

// File: verif/jitter_checker.sv
`timescale 1ns / 1ps

module jitter_checker import pawja_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [IDX_W-1:0]        atom_index,
  input  logic                    atom_fixed,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic signed [POS_W-1:0] pos_z,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic [IDX_W-1:0]        atom_echo,
  input  logic [POS_W-1:0]        average_jitter,
  input  logic                    average_valid,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [1:0]              paddr,
  input  logic [31:0]             pwdata,
  input  logic                    pready,
  output int                      errors,
  output int                      pending
);

  localparam int ATOMS = 1024;
  localparam int SLOTS = 16;

  typedef struct packed {
    logic [IDX_W-1:0] atom;
    logic [POS_W-1:0] avg;
    logic             valid;
  } avg_result_t;

  avg_result_t               averages_due[$];
  logic [RK_W-1:0]           window_reg;
  int unsigned               seen[ATOMS];
  int unsigned               ring_ptr[ATOMS];
  longint unsigned           jit_sum[ATOMS];
  logic signed [POS_W-1:0]   last_x[ATOMS];
  logic signed [POS_W-1:0]   last_y[ATOMS];
  logic signed [POS_W-1:0]   last_z[ATOMS];
  logic [POS_W-1:0]          jit_ring[ATOMS][SLOTS];

  initial errors = 0;
  initial pending = 0;

  function automatic longint unsigned int_root(longint unsigned n);
    longint unsigned r = 0;
    longint unsigned b = 64'h1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned sq(longint d);
    return (d < 0) ? longint'(-d) * longint'(-d) : d * d;
  endfunction

  task automatic restart_windows();
    for (int i = 0; i < ATOMS; i++) begin
      seen[i] = 0;
      ring_ptr[i] = 0;
      jit_sum[i] = 0;
    end
  endtask

  // Updates the atom record and returns the average it then reports.
  function automatic avg_result_t next_average(int unsigned idx, logic fixed,
      logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y,
      logic signed [POS_W-1:0] z);
    avg_result_t     res;
    int unsigned     win;
    int unsigned     cur;
    int unsigned     nxt;
    longint unsigned jit;
    longint unsigned old;
    longint unsigned avg;
    res.atom  = idx[IDX_W-1:0];
    res.avg   = '0;
    res.valid = 1'b0;
    win = (window_reg < 2) ? 2 : (window_reg > SLOTS) ? SLOTS : window_reg;
    if (!fixed) begin
      if (seen[idx] == 0) begin
        seen[idx] = 1;
      end else begin
        jit = int_root(sq(longint'(x) - longint'(last_x[idx]))
                     + sq(longint'(y) - longint'(last_y[idx]))
                     + sq(longint'(z) - longint'(last_z[idx])));
        if (jit > JIT_MAX) jit = JIT_MAX;
        cur = ring_ptr[idx] % win;
        nxt = (cur + 1) % win;
        if (seen[idx] >= win) begin
          old = jit_ring[idx][nxt];
          jit_sum[idx] = (jit_sum[idx] >= old) ? jit_sum[idx] - old : 0;
          seen[idx] = win;
        end else begin
          seen[idx]++;
        end
        ring_ptr[idx] = nxt;
        jit_ring[idx][cur] = jit[POS_W-1:0];
        jit_sum[idx] += jit;
      end
      last_x[idx] = x;
      last_y[idx] = y;
      last_z[idx] = z;
    end
    if (seen[idx] >= 2) begin
      avg = jit_sum[idx] / (seen[idx] - 1);
      res.avg   = (avg > JIT_MAX) ? JIT_MAX : avg[POS_W-1:0];
      res.valid = 1'b1;
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    avg_result_t want;
    if (rst) begin
      window_reg = RK_RESET;
      restart_windows();
      for (int i = 0; i < ATOMS; i++) begin
        last_x[i] = '0;
        last_y[i] = '0;
        last_z[i] = '0;
        for (int s = 0; s < SLOTS; s++) jit_ring[i][s] = '0;
      end
      averages_due.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == REG_RECORDS_KEPT) begin
        window_reg = pwdata[RK_W-1:0];
        restart_windows();
      end
      if (in_valid && !in_stall)
        averages_due.push_back(next_average(atom_index, atom_fixed,
                                            pos_x, pos_y, pos_z));
      if (out_valid && !out_stall) begin
        if (averages_due.size() == 0) begin
          report_mismatch("unexpected result, atom", atom_echo, -1);
        end else begin
          want = averages_due.pop_front();
          if (atom_echo !== want.atom)
            report_mismatch("atom_echo", atom_echo, want.atom);
          if (average_jitter !== want.avg)
            report_mismatch("average_jitter", average_jitter, want.avg);
          if (average_valid !== want.valid)
            report_mismatch("average_valid", average_valid, want.valid);
        end
      end
    end
    pending = averages_due.size();
  end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import pawja_pkg::*;

  localparam int PHASE_ITEMS = 190;   // random items per window setting
  localparam int HOLD_CYCLES = 400;   // long receiver hold-off
  localparam int TAIL_CYCLES = 120;   // longest item latency plus margin

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [IDX_W-1:0]        atom_index = '0;
  logic                    atom_fixed = 1'b0;
  logic signed [POS_W-1:0] pos_x = '0;
  logic signed [POS_W-1:0] pos_y = '0;
  logic signed [POS_W-1:0] pos_z = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [IDX_W-1:0]        atom_echo;
  logic [POS_W-1:0]        average_jitter;
  logic                    average_valid;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [1:0]              paddr = '0;
  logic [31:0]             pwdata = '0;
  logic [31:0]             prdata;
  logic                    pready;

  int errors;
  int pending;

  // idle rates in percent, set per phase by the stimulus
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // long hold-off request: stimulus flips hold_req, receiver counts it down
  bit hold_req = 1'b0;
  bit hold_ack = 1'b0;
  int hold_left = 0;

  per_atom_windowed_jitter_average u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .atom_index(atom_index), .atom_fixed(atom_fixed),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .atom_echo(atom_echo), .average_jitter(average_jitter),
    .average_valid(average_valid),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  jitter_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .atom_index(atom_index), .atom_fixed(atom_fixed),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .atom_echo(atom_echo), .average_jitter(average_jitter),
    .average_valid(average_valid),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .errors(errors), .pending(pending)
  );

  always #5 clk = ~clk;

  // Safety net: fails the run if it has not finished by the time limit.
  initial begin
    #20_000_000;
    $display("FAIL per_atom_windowed_jitter_average");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off on request so the
  // block backs up and stalls its input.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Offers one item, returns at the edge where it is taken. Entered at a
  // rising edge; a gap drops valid first, otherwise valid stays high.
  task automatic send_item(int unsigned idx, bit fixed, int x, int y, int z);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    atom_index <= idx[IDX_W-1:0];
    atom_fixed <= fixed;
    pos_x      <= x[POS_W-1:0];
    pos_y      <= y[POS_W-1:0];
    pos_z      <= z[POS_W-1:0];
    do @(posedge clk); while (in_stall);
  endtask

  // Mostly a handful of atoms with small moves so windows fill and wrap;
  // now and then any atom and any position.
  task automatic send_random_item();
    int unsigned idx;
    int          p[3];
    idx = ($urandom_range(9) < 8) ? $urandom_range(15) : $urandom_range(1023);
    for (int k = 0; k < 3; k++)
      p[k] = ($urandom_range(6) == 0) ? int'($urandom())
                                      : int'($urandom_range(8191)) - 4096;
    send_item(idx, $urandom_range(9) == 0, p[0], p[1], p[2]);
  endtask

  // Sender pause: nothing offered until every result is back. One edge
  // first so the count includes the item taken at the entry edge.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_records_kept(logic [RK_W-1:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= REG_RECORDS_KEPT;
    pwdata  <= 32'(value);
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  localparam int MAXP =  8388607;
  localparam int MINP = -8388608;

  logic [RK_W-1:0] window_plan[6] = '{5'd2, 5'd31, 5'd0, 5'd7, 5'd1, 5'd16};

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part, default window of 16.
    send_item(0, 0, MAXP, MAXP, MAXP);       // first position only stored
    send_item(0, 0, MINP, MINP, MINP);       // largest move, saturates
    send_item(0, 1, 0, 0, 0);                // fixed atom reports average
    send_item(1023, 1, 5, 5, 5);             // fixed atom never seen
    send_item(1023, 0, 0, 0, 0);
    send_item(1023, 0, 0, 0, 0);             // zero move
    send_item(1023, 0, 4096, -4096, 1);
    for (int k = 0; k < 16; k++)             // fill and wrap atom 0's window
      send_item(0, 0, k * 1000, -k * 77, 3 - k);

    for (int ph = 0; ph < 7; ph++) begin
      if (ph > 0) begin
        drain();
        write_records_kept(window_plan[ph-1]);
      end
      // sender 25 / receiver 66, then swapped, then no idling
      case (ph % 3)
        0: begin send_idle_pct = 25; recv_idle_pct = 66; end
        1: begin send_idle_pct = 66; recv_idle_pct = 25; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 2 && n == 20) hold_req = ~hold_req;
        if (ph == 4 && n == 90) drain();
        send_random_item();
      end
    end

    drain();
    if (errors == 0) begin
      $display("PASS per_atom_windowed_jitter_average");
    end else begin
      $display("FAIL per_atom_windowed_jitter_average");
    end
    $finish;
  end

endmodule

// File: files.f
src/pawja_pkg.sv
src/per_atom_windowed_jitter_average.sv
src/pawja_check.sv
verif/jitter_checker.sv
verif/tb.sv
